// ===== design/packet_frame_checker_defines.svh =====
// Assertion macros shared by the frame checker RTL.
// All macros sample on clk and are disabled while arst_n is low.
`ifndef PACKET_FRAME_CHECKER_DEFINES_SVH
`define PACKET_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define PFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pfc_pkg.sv =====
package pfc_pkg;

	localparam int QUEUE_DEPTH = 8;

	localparam logic [11:0] COUNT_MAX  = 12'd4095;
	localparam logic [11:0] CRC_START  = 12'd2;   // bytes leave the delay line from here
	localparam logic [11:0] PAYLOAD_AT = 12'd8;   // leaving bytes are payload from this offset on
	localparam logic [11:0] HDR_LEN    = 12'd6;
	localparam logic [11:0] LAST_SHORT = 12'd6;   // final byte at or below this offset: short
	localparam logic [11:0] LEN_BASE   = 12'd7;   // final offset minus this is the payload length
	localparam logic [26:0] DAY_MS     = 27'd86400000;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_CRC    = 3'd2,
		ST_LENGTH = 3'd3,
		ST_STAMP  = 3'd4
	} status_t;

	typedef struct packed {
		logic        is_status;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [26:0] stamp_ms;
		logic [5:0]  topic_id;
		logic [3:0]  command_id;
		logic [10:0] declared_length;
		logic        last_item;
	} out_item_t;

	// Queue write request: up to two items per cycle, item0 first.
	typedef struct packed {
		logic [1:0] num;
		out_item_t  item0;
		out_item_t  item1;
	} push_t;

	// CRC-16/XMODEM, one byte, MSB first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== design/pfc_out_queue.sv =====
module pfc_out_queue #(
	parameter int DEPTH = pfc_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pfc_pkg::push_t             push,
	output logic [$clog2(DEPTH+1)-1:0] level,
	output logic                       out_valid,
	input  logic                       out_stall,
	output pfc_pkg::out_item_t         out_item
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	pfc_pkg::out_item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] wr_next, wr_next2, rd_next;
	logic          pop;

	always_comb begin
		wr_next  = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
		wr_next2 = (wr_next == AW'(DEPTH - 1)) ? '0 : wr_next + 1'b1;
		rd_next  = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	end

	assign pop       = (count_q != '0) && !out_stall;
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign level     = count_q;

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.item0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_next] <= push.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.num == 2'd1) begin
				wr_ptr_q <= wr_next;
			end else if (push.num == 2'd2) begin
				wr_ptr_q <= wr_next2;
			end
			if (pop) begin
				rd_ptr_q <= rd_next;
			end
			count_q <= count_q + CW'(push.num) - CW'(pop);
		end
	end

endmodule

// ===== design/packet_frame_checker.sv =====
// Channel  Direction  Handshake          Fields
// in       sink       in_valid/in_stall  rx_byte, end_of_frame
// out      source     out_valid/out_stall is_status, payload_byte, status, stamp_ms,
//                                        topic_id, command_id, declared_length, last_item
//
// A byte is registered at its transfer and handled in s1 the next cycle; its results
// (none, one or two) are written to the output queue at the end of that cycle, so a
// result shows on out no earlier than the cycle after s1.
// The final byte of a frame may give two results: a payload byte, then the status.
// in_stall rises when the queue could not hold two results each from the byte in s1
// and a new byte, else a byte transfers every cycle; out_stall backs up through the
// queue. arst_n clears the pipeline, queue pointers, byte counter and CRC.
`include "packet_frame_checker_defines.svh"

module packet_frame_checker #(
	parameter int QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_frame,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_status,
	output logic [7:0]  payload_byte,
	output logic [2:0]  status,
	output logic [26:0] stamp_ms,
	output logic [5:0]  topic_id,
	output logic [3:0]  command_id,
	output logic [10:0] declared_length,
	output logic        last_item
);

	localparam int CW       = $clog2(QUEUE_DEPTH + 1);
	localparam int STALL_AT = QUEUE_DEPTH - 2;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// Frame state
	logic [11:0] byte_count_q;   // offset of the next byte, saturates
	logic [15:0] crc_q;          // CRC of bytes that left the delay line
	logic [7:0]  hdr_q [6];
	logic [7:0]  dly_q [2];      // [0] newest

	logic              in_xfer;
	logic [CW-1:0]     level;
	logic [CW+1:0]     need;
	pfc_pkg::push_t    push;
	pfc_pkg::out_item_t pay_item, stat_item, head;

	logic [15:0]  crc_next;
	logic         leaves, emit_pay;
	logic [26:0]  dec_stamp;
	logic [5:0]   dec_topic;
	logic [3:0]   dec_cmd;
	logic [10:0]  dec_len;
	logic [11:0]  got_len;
	pfc_pkg::status_t st;

	// Stall when a new byte could not be sure of room for its two results.
	assign need     = (CW + 2)'(level) + {{CW{1'b0}}, valid_s1, 1'b0};
	assign in_stall = need > (CW + 2)'(STALL_AT);
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= rx_byte;
			eof_s1  <= end_of_frame;
		end
	end

	// s1: CRC over the byte leaving the delay line, header decode, status checks
	always_comb begin
		leaves   = byte_count_q >= pfc_pkg::CRC_START;
		emit_pay = byte_count_q >= pfc_pkg::PAYLOAD_AT;
		crc_next = leaves ? pfc_pkg::crc_feed(crc_q, dly_q[1]) : crc_q;

		dec_stamp = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3][7:5]};
		dec_topic = {hdr_q[3][4:0], hdr_q[4][7]};
		dec_cmd   = hdr_q[4][6:3];
		dec_len   = {hdr_q[4][2:0], hdr_q[5]};
		// a saturated count always lands far above any 11-bit length
		got_len   = byte_count_q - pfc_pkg::LEN_BASE;

		priority if (byte_count_q <= pfc_pkg::LAST_SHORT) begin
			st = pfc_pkg::ST_SHORT;
		end else if ({dly_q[0], byte_s1} != crc_next) begin
			st = pfc_pkg::ST_CRC;
		end else if (got_len != {1'b0, dec_len}) begin
			st = pfc_pkg::ST_LENGTH;
		end else if (dec_stamp >= pfc_pkg::DAY_MS) begin
			st = pfc_pkg::ST_STAMP;
		end else begin
			st = pfc_pkg::ST_OK;
		end

		pay_item              = '0;
		pay_item.status       = pfc_pkg::ST_OK;
		pay_item.payload_byte = dly_q[1];

		stat_item           = '0;
		stat_item.is_status = 1'b1;
		stat_item.last_item = 1'b1;
		stat_item.status    = st;
		if (st != pfc_pkg::ST_SHORT && st != pfc_pkg::ST_CRC) begin
			stat_item.stamp_ms        = dec_stamp;
			stat_item.topic_id        = dec_topic;
			stat_item.command_id      = dec_cmd;
			stat_item.declared_length = dec_len;
		end

		push.num   = 2'(valid_s1 && emit_pay) + 2'(valid_s1 && eof_s1);
		push.item0 = emit_pay ? pay_item : stat_item;
		push.item1 = stat_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			crc_q        <= '0;
		end else if (valid_s1) begin
			if (eof_s1) begin
				byte_count_q <= '0;
				crc_q        <= '0;
			end else begin
				crc_q <= crc_next;
				if (byte_count_q != pfc_pkg::COUNT_MAX) begin
					byte_count_q <= byte_count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			dly_q[1] <= dly_q[0];
			dly_q[0] <= byte_s1;
			if (byte_count_q < pfc_pkg::HDR_LEN) begin
				hdr_q[byte_count_q[2:0]] <= byte_s1;
			end
		end
	end

	pfc_out_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.level    (level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (head)
	);

	assign is_status       = head.is_status;
	assign payload_byte    = head.payload_byte;
	assign status          = head.status;
	assign stamp_ms        = head.stamp_ms;
	assign topic_id        = head.topic_id;
	assign command_id      = head.command_id;
	assign declared_length = head.declared_length;
	assign last_item       = head.last_item;

	// Closing byte resets the running frame state.
	`PFC_ASSERT_NEXT(a_eof_clears, valid_s1 && eof_s1,
		byte_count_q == '0 && crc_q == '0, "frame state not cleared after final byte")
	// Byte counter holds once saturated.
	`PFC_ASSERT_NEXT(a_count_sat,
		valid_s1 && !eof_s1 && byte_count_q == pfc_pkg::COUNT_MAX,
		byte_count_q == pfc_pkg::COUNT_MAX, "byte counter wrapped")
	// Short and bad-CRC frames carry no decoded header.
	`PFC_ASSERT_NOW(a_bad_frame_zero,
		out_valid && is_status && (status == pfc_pkg::ST_SHORT || status == pfc_pkg::ST_CRC),
		stamp_ms == '0 && topic_id == '0 && command_id == '0 && declared_length == '0,
		"decoded fields leak on rejected frame")

endmodule

// ===== tb/sv/pfc_result_checker.sv =====
`timescale 1ns / 100ps

package pfc_tb_crc_pkg;

	// CRC-16/XMODEM, one byte, fed MSB first, one bit at a time
	function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ pfc_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

module pfc_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_frame,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        is_status,
	input  logic [7:0]  payload_byte,
	input  logic [2:0]  status,
	input  logic [26:0] stamp_ms,
	input  logic [5:0]  topic_id,
	input  logic [3:0]  command_id,
	input  logic [10:0] declared_length,
	input  logic        last_item,
	output int          fail_count,
	output int          due_count,
	output int          checked_count
);

	pfc_pkg::out_item_t due_items[$];
	logic [11:0] frame_bytes_seen;
	logic        count_full;
	logic [15:0] running_crc;
	logic [7:0]  hdr_copy[6];
	logic [7:0]  held[2];        // [0] newest, [1] older

	initial begin
		fail_count = 0;
		due_count = 0;
		checked_count = 0;
	end

	// one accepted byte: queue the payload and/or status items it releases
	task automatic absorb_byte(input logic [7:0] b, input logic last);
		pfc_pkg::out_item_t item;
		logic [11:0] idx;
		logic [7:0]  leaving;
		logic [26:0] stamp_v;
		logic [5:0]  topic_v;
		logic [3:0]  cmd_v;
		logic [10:0] len_v;
		idx = frame_bytes_seen;
		if (idx >= pfc_pkg::CRC_START) begin
			leaving = held[1];
			running_crc = pfc_tb_crc_pkg::crc16_xmodem_byte(running_crc, leaving);
			if (idx >= pfc_pkg::PAYLOAD_AT) begin
				item = '0;
				item.payload_byte = leaving;
				due_items.insert(due_items.size(), item);
			end
		end
		held[1] = held[0];
		held[0] = b;
		if (idx < pfc_pkg::HDR_LEN) begin
			hdr_copy[idx[2:0]] = b;
		end
		if (idx == pfc_pkg::COUNT_MAX) begin
			count_full = 1'b1;
		end else begin
			frame_bytes_seen = idx + 12'd1;
		end
		if (last) begin
			item = '0;
			item.is_status = 1'b1;
			item.last_item = 1'b1;
			item.status = pfc_pkg::ST_OK;
			if (!count_full && idx <= pfc_pkg::LAST_SHORT) begin
				item.status = pfc_pkg::ST_SHORT;
			end else if ({held[1], held[0]} != running_crc) begin
				item.status = pfc_pkg::ST_CRC;
			end else begin
				stamp_v = {hdr_copy[0], hdr_copy[1], hdr_copy[2], hdr_copy[3][7:5]};
				topic_v = {hdr_copy[3][4:0], hdr_copy[4][7]};
				cmd_v = hdr_copy[4][6:3];
				len_v = {hdr_copy[4][2:0], hdr_copy[5]};
				item.stamp_ms = stamp_v;
				item.topic_id = topic_v;
				item.command_id = cmd_v;
				item.declared_length = len_v;
				if (count_full || (idx - pfc_pkg::LEN_BASE) != {1'b0, len_v}) begin
					item.status = pfc_pkg::ST_LENGTH;
				end else if (stamp_v >= pfc_pkg::DAY_MS) begin
					item.status = pfc_pkg::ST_STAMP;
				end
			end
			due_items.insert(due_items.size(), item);
			frame_bytes_seen = '0;
			count_full = 1'b0;
			running_crc = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : watch
		pfc_pkg::out_item_t want;
		if (!arst_n) begin
			due_items.delete();
			frame_bytes_seen = '0;
			count_full = 1'b0;
			running_crc = '0;
			due_count <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				absorb_byte(rx_byte, end_of_frame);
			end
			if (out_valid && !out_stall) begin
				if (due_items.size() == 0) begin
					$display("%0t: unexpected result, expected nothing, got is_status=%0b status=%0d",
						$time, is_status, status);
					fail_count++;
				end else begin
					want = due_items.pop_front();
					check_field("is_status", want.is_status, is_status);
					check_field("payload_byte", want.payload_byte, payload_byte);
					check_field("status", want.status, status);
					check_field("stamp_ms", want.stamp_ms, stamp_ms);
					check_field("topic_id", want.topic_id, topic_id);
					check_field("command_id", want.command_id, command_id);
					check_field("declared_length", want.declared_length, declared_length);
					check_field("last_item", want.last_item, last_item);
					checked_count++;
				end
			end
			due_count <= due_items.size();
		end
	end

endmodule

// ===== tb/sv/tb_packet_frame_checker.sv =====
`timescale 1ns / 100ps

module tb_packet_frame_checker;

	// cycles with no progress before the run is declared hung;
	// worst case is a full sender gap plus a full receiver stall plus pipeline
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_BYTES = 780;
	localparam int DRAIN_CYCLES = 16;   // pipeline plus output queue, with margin

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        end_of_frame;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        is_status;
	logic [7:0]  payload_byte;
	logic [2:0]  status;
	logic [26:0] stamp_ms;
	logic [5:0]  topic_id;
	logic [3:0]  command_id;
	logic [10:0] declared_length;
	logic        last_item;

	int fail_count;
	int due_count;
	int checked_count;

	logic [7:0] frame_q[$];    // frame being built for transmission
	bit         send_quiet = 1'b0;
	bit         recv_quiet = 1'b0;
	int         recv_gap;
	int         recv_wait;
	int         idle_cycles;
	int         frames_sent = 0;
	int         bytes_sent = 0;

	packet_frame_checker uut (.*);

	pfc_result_checker result_chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: after each result transfer, draw a random stall, which may be none.
	// Quiet mode (toggled now and then) takes every result back to back.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait <= 0;
		end else if (out_valid && !out_stall) begin
			if ($urandom_range(0, 31) == 0) begin
				recv_quiet = !recv_quiet;
			end
			recv_gap = recv_quiet ? 0 : $urandom_range(0, 19);
			if (recv_gap == 0) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				recv_wait <= recv_gap - 1;
			end
		end else if (out_stall) begin
			if (recv_wait == 0) begin
				out_stall <= 1'b0;
			end else begin
				recv_wait <= recv_wait - 1;
			end
		end
	end

	// Hang detector: an input transfer, or a result transfer while results
	// are still owed, restarts the count.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall && due_count != 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
				$time, IDLE_LIMIT, due_count);
			$display("[packet_frame_checker] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// One byte transfer. Valid only drops when a gap is drawn, so back to back
	// bytes keep it high across the edge; it returns at the transfer edge.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		end_of_frame <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i]) begin
			send_byte(frame_q[i], i == frame_q.size() - 1);
		end
		frames_sent++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		frame_q.insert(frame_q.size(), b);
	endtask

	// Header is packed big-endian: 27-bit stamp, 6-bit topic, 4-bit command,
	// 11-bit length. CRC covers header and payload, sent high byte first.
	task automatic make_frame(input logic [26:0] stamp, input logic [5:0] topic,
			input logic [3:0] cmd, input logic [10:0] len, input int payload_n);
		logic [15:0] crc;
		frame_q.delete();
		add_byte(stamp[26:19]);
		add_byte(stamp[18:11]);
		add_byte(stamp[10:3]);
		add_byte({stamp[2:0], topic[5:1]});
		add_byte({topic[0], cmd, len[10:8]});
		add_byte(len[7:0]);
		repeat (payload_n) add_byte(8'($urandom_range(0, 255)));
		crc = '0;
		foreach (frame_q[i]) begin
			crc = pfc_tb_crc_pkg::crc16_xmodem_byte(crc, frame_q[i]);
		end
		add_byte(crc[15:8]);
		add_byte(crc[7:0]);
	endtask

	// single-bit error anywhere in the frame: always caught by the CRC
	task automatic corrupt_frame();
		int pos;
		pos = $urandom_range(0, frame_q.size() - 1);
		frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
	endtask

	// Hold the sender off until the output side has delivered everything.
	// The first edge lets the outstanding count catch up with the last transfer.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
	endtask

	initial begin
		int          kind;
		int          plen;
		int          base_bytes;
		int          noise_n;
		logic [26:0] stamp;
		logic [10:0] len_field;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		end_of_frame = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one-byte frame and a 7-byte frame are both too short.
		frame_q = {8'hFF};
		send_frame();
		frame_q.delete();
		repeat (7) add_byte(8'h00);
		send_frame();
		// minimum 8-byte frame, stamp, topic and command at maximum: stamp overflow
		make_frame(27'h7FFFFFF, 6'h3F, 4'hF, 11'd0, 0);
		send_frame();
		// 9-byte frame: final byte releases a payload item and the status item
		make_frame(27'd0, 6'd0, 4'd0, 11'd1, 1);
		send_frame();
		wait_drained();

		// Random: mostly well-formed frames, with bad CRC, wrong length,
		// short frames and plain noise mixed in.
		base_bytes = bytes_sent;
		while (bytes_sent < base_bytes + RANDOM_BYTES) begin
			if ($urandom_range(0, 7) == 0) begin
				send_quiet = !send_quiet;
			end
			case ($urandom_range(0, 7))
				0: stamp = pfc_pkg::DAY_MS - 27'd1;
				1: stamp = pfc_pkg::DAY_MS;
				2, 3: stamp = 27'($urandom_range(0, 27'h7FFFFFF));
				default: stamp = 27'($urandom_range(0, pfc_pkg::DAY_MS - 27'd1));
			endcase
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				make_frame(stamp, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
					11'(plen), plen);
				if (kind >= 60) begin
					corrupt_frame();
				end
			end else if (kind < 88) begin
				// declared length disagrees with what is actually sent
				len_field = $urandom_range(0, 1) ? 11'(plen + 1) : 11'($urandom_range(0, 2047));
				if (len_field == 11'(plen)) begin
					len_field = 11'(plen + 2);
				end
				make_frame(stamp, 6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
					len_field, plen);
			end else begin
				frame_q.delete();
				noise_n = (kind < 95) ? $urandom_range(1, 7) : $urandom_range(1, 40);
				repeat (noise_n) begin
					add_byte(8'($urandom_range(0, 255)));
				end
			end
			send_frame();
			if ($urandom_range(0, 29) == 0) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d frames (%0d bytes): short, bad CRC, bad length, stamp overflow",
			frames_sent, bytes_sent);
		$display("and noise frames under random stalls; %0d results compared, %0d failures",
			checked_count, fail_count);
		if (fail_count == 0) begin
			$display("[packet_frame_checker] OK");
		end else begin
			$display("[packet_frame_checker] ERROR");
		end
		$finish;
	end

endmodule
